// ----- src/lwpw_pkg.sv -----
// Shared types, constants and helpers of the LCD window pixel writer.
// No dependencies; imported by every module of the block.
package lwpw_pkg;

  localparam int DISPLAY_WIDTH  = 240;
  localparam int DISPLAY_HEIGHT = 320;
  localparam int FRAME_WIDTH    = 240;
  localparam int FRAME_HEIGHT   = 320;
  localparam int OFFSET_X       = FRAME_WIDTH / 2 - DISPLAY_WIDTH / 2;
  localparam int OFFSET_Y       = FRAME_HEIGHT / 2 - DISPLAY_HEIGHT / 2;

  localparam int COLOR_W  = 16;
  localparam int ADDR_W   = 17;
  localparam int RGB_W    = 24;
  localparam int POS_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int CURSOR_W = 11;
  localparam int EDGE_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 2'd3;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [RGB_W-1:0]  rgb_color;
  } result_t;

  // RGB565 to RGB888, low bits of each channel zero
  function automatic logic [RGB_W-1:0] expand_rgb(input logic [COLOR_W-1:0] c);
    expand_rgb = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
  endfunction

endpackage

// ----- src/lwpw_cursor.sv -----
// Window registers, auto-increment cursor and per-pixel address/color logic.
// Depends on lwpw_pkg.
module lwpw_cursor
  import lwpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 step,
  input  logic [COLOR_W-1:0]   pixel_color,
  output result_t              res
);

  logic [POS_W-1:0]    left_r, left_nxt;
  logic [POS_W-1:0]    top_r, top_nxt;
  logic [SIZE_W-1:0]   width_r, width_nxt;
  logic [SIZE_W-1:0]   height_r, height_nxt;
  logic [CURSOR_W-1:0] col_r, col_nxt;
  logic [CURSOR_W-1:0] row_r, row_nxt;

  logic [EDGE_W-1:0] right_end;
  logic [EDGE_W-1:0] bottom_end;
  logic              in_window;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] row_off;
  logic [ADDR_W-1:0] addr;

  // exclusive edges: no negative values for an empty window
  assign right_end  = EDGE_W'(left_r) + EDGE_W'(width_r);
  assign bottom_end = EDGE_W'(top_r) + EDGE_W'(height_r);

  assign in_window = (col_r >= CURSOR_W'(left_r)) && (EDGE_W'(col_r) < right_end) &&
                     (row_r >= CURSOR_W'(top_r)) && (EDGE_W'(row_r) < bottom_end) &&
                     (col_r < CURSOR_W'(DISPLAY_WIDTH)) && (row_r < CURSOR_W'(DISPLAY_HEIGHT));

  assign last_col = (EDGE_W'(col_r) + EDGE_W'(1)) == right_end;
  assign last_row = (EDGE_W'(row_r) + EDGE_W'(1)) == bottom_end;

  // row * 240 as (row << 8) - (row << 4)
  assign row_off = ADDR_W'(row_r) + ADDR_W'(OFFSET_Y);
  assign addr    = (row_off << 8) - (row_off << 4) + ADDR_W'(col_r) + ADDR_W'(OFFSET_X);

  always_comb begin
    res.write_enable  = in_window;
    res.pixel_address = in_window ? addr : '0;
    res.rgb_color     = in_window ? expand_rgb(pixel_color) : '0;
  end

  always_comb begin
    left_nxt   = left_r;
    top_nxt    = top_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEFT:   left_nxt   = cfg_wdata[POS_W-1:0];
        CFG_WINDOW_TOP:    top_nxt    = cfg_wdata[POS_W-1:0];
        CFG_WINDOW_WIDTH:  width_nxt  = cfg_wdata;
        CFG_WINDOW_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
      // home the cursor to the (new) origin
      col_nxt = CURSOR_W'(left_nxt);
      row_nxt = CURSOR_W'(top_nxt);
    end else if (step && in_window) begin
      if (last_col) begin
        col_nxt = CURSOR_W'(left_r);
        row_nxt = last_row ? CURSOR_W'(top_r) : row_r + CURSOR_W'(1);
      end else begin
        col_nxt = col_r + CURSOR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ----- src/lwpw_out_buf.sv -----
// Result register with a skid stage that takes one more input beat under stall.
// Depends on lwpw_pkg.
module lwpw_out_buf
  import lwpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_beat,
  input  result_t in_res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ready) begin
      // advance: skid first, else the new beat
      out_v_nxt  = skid_v_r || in_beat;
      out_d_nxt  = skid_v_r ? skid_d_r : in_res;
      skid_v_nxt = 1'b0;
    end else if (in_beat) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = in_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while result register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ready |=> skid_v_r && $stable(skid_d_r))
    else $error("skid stage lost a beat under stall");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_d_r.write_enable |->
      out_d_r.pixel_address == '0 && out_d_r.rgb_color == '0)
    else $error("dropped pixel carries nonzero payload");

  a_no_beat_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_beat)
    else $error("beat taken with skid stage full");

endmodule

// ----- src/lcd_window_pixel_writer.sv -----
// LCD window pixel writer: graphics RAM write path with windowed cursor.
// Input channel in_*: one RGB565 pixel per beat (in_tdata[15:0] = pixel_color).
// Output channel out_*: one result per input beat. out_tuser = write_enable;
//   out_tdata holds the frame store address and the RGB888 color.
// Config port cfg_*: cfg_index selects window_left, window_top, window_width,
//   window_height; any write moves the cursor to the window origin.
// A result is registered: in the result register, or in the skid stage under stall.
// Throughput: one pixel per cycle while in_tready is high; the cursor update and
//   address arithmetic (row * 240 as shift and subtract) fit in the single stage
//   before the result register.
// Reset (rst_n low, synchronous): window 0,0 of size 1x1, cursor at 0,0,
//   both output stages empty.
// When the receiver stalls, the result register holds and one more beat
//   lands in a skid stage; in_tready drops only while that stage is full.
// Pixels outside the window or display give write_enable 0 with zero payload
//   and leave the cursor in place.
module lcd_window_pixel_writer
  import lwpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [COLOR_W-1:0]   in_tdata,   // [15:0] pixel_color
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [16:0] pixel_address, [40:17] rgb_color
  output logic                 out_tuser,  // [0] write_enable
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  logic    in_beat;
  result_t step_res;
  result_t out_res;

  assign in_beat = in_tvalid && in_tready;

  lwpw_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .step        (in_beat),
    .pixel_color (in_tdata),
    .res         (step_res)
  );

  lwpw_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .in_res    (step_res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.write_enable;
  assign out_tdata = {(DATA_W - ADDR_W - RGB_W)'(0), out_res.rgb_color,
                      out_res.pixel_address};

endmodule

// ----- dv/tb_lcd_window_pixel_writer.sv -----
// Self-checking testbench for lcd_window_pixel_writer: window setup, cursor walk,
// display clipping and RGB565 to RGB888 expansion, with random idling on both sides.
// Depends on lwpw_pkg and the lcd_window_pixel_writer RTL only.
module tb_lcd_window_pixel_writer;
  import lwpw_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [COLOR_W-1:0]   in_tdata;   // [15:0] pixel_color
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;  // [16:0] pixel_address, [40:17] rgb_color
  logic                 out_tuser;  // [0] write_enable
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;

  lcd_window_pixel_writer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Mirror of the window registers and the write cursor
  logic [POS_W-1:0]    win_left;
  logic [POS_W-1:0]    win_top;
  logic [SIZE_W-1:0]   win_width;
  logic [SIZE_W-1:0]   win_height;
  logic [CURSOR_W-1:0] cur_col;
  logic [CURSOR_W-1:0] cur_row;

  result_t pending_writes[$];

  int gap_pct;
  int stall_pct;
  int hold_cycles;
  int error_count;
  int pixels_sent;
  int pixels_written;
  int pixels_dropped;
  int reg_writes;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic result_t predict_gram_write(input logic [COLOR_W-1:0] color);
    result_t r;
    int col, row, right_edge, bottom_edge;
    logic [RGB_W-1:0] c24;
    col = cur_col;
    row = cur_row;
    right_edge = int'(win_left) + int'(win_width) - 1;
    bottom_edge = int'(win_top) + int'(win_height) - 1;
    r = '0;
    if (col >= int'(win_left) && col <= right_edge && row >= int'(win_top) &&
        row <= bottom_edge && col < DISPLAY_WIDTH && row < DISPLAY_HEIGHT) begin
      c24 = {8'h00, color};
      r.write_enable = 1'b1;
      r.pixel_address = ADDR_W'((row + OFFSET_Y) * FRAME_WIDTH + col + OFFSET_X);
      r.rgb_color = ((c24 & 24'h00F800) << 8) | ((c24 & 24'h0007E0) << 5) |
                    ((c24 & 24'h00001F) << 3);
      // advance along the row, wrap to next row, then back to the top
      if (col == right_edge) begin
        cur_col = CURSOR_W'(win_left);
        cur_row = (row == bottom_edge) ? CURSOR_W'(win_top) : CURSOR_W'(row + 1);
      end else begin
        cur_col = CURSOR_W'(col + 1);
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_LEFT:   win_left = value[POS_W-1:0];
      CFG_WINDOW_TOP:    win_top = value[POS_W-1:0];
      CFG_WINDOW_WIDTH:  win_width = value;
      CFG_WINDOW_HEIGHT: win_height = value;
      default: ;
    endcase
    cur_col = CURSOR_W'(win_left);
    cur_row = CURSOR_W'(win_top);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(input logic [SIZE_W-1:0] left, input logic [SIZE_W-1:0] top,
                            input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height);
    write_reg(CFG_WINDOW_LEFT, left);
    write_reg(CFG_WINDOW_TOP, top);
    write_reg(CFG_WINDOW_WIDTH, width);
    write_reg(CFG_WINDOW_HEIGHT, height);
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] color);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= color;
    do @(posedge clk); while (!in_tready);
    pending_writes.push_back(predict_gram_write(color));
    pixels_sent++;
  endtask

  // Hold the input idle until every result has come back
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected result we=%0b addr=%0d rgb=%06h", $time,
                 out_tuser, out_tdata[16:0], out_tdata[40:17]);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (out_tuser !== want.write_enable) begin
          $display("%0t: write_enable expected %0b actual %0b", $time,
                   want.write_enable, out_tuser);
          error_count++;
        end
        if (out_tdata[16:0] !== want.pixel_address) begin
          $display("%0t: pixel_address expected %0d actual %0d", $time,
                   want.pixel_address, out_tdata[16:0]);
          error_count++;
        end
        if (out_tdata[40:17] !== want.rgb_color) begin
          $display("%0t: rgb_color expected %06h actual %06h", $time,
                   want.rgb_color, out_tdata[40:17]);
          error_count++;
        end
        if (want.write_enable) pixels_written++;
        else pixels_dropped++;
      end
    end
  end

  task automatic test_reset_window;
    // reset window is 1x1 at the origin: every pixel lands on address zero
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    drain();
  endtask

  task automatic test_color_channels;
    set_window(11'd0, 11'd0, 11'd3, 11'd1);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    drain();
  endtask

  task automatic test_display_corner;
    set_window(11'd238, 11'd318, 11'd2, 11'd2);
    repeat (5) send_pixel(16'($urandom));
    drain();
  endtask

  task automatic test_window_past_edge;
    // cursor runs into the right edge of the display and sticks there
    set_window(11'd237, 11'd0, 11'd1024, 11'd1);
    repeat (4) send_pixel(16'($urandom));
    drain();
    // same on the bottom edge
    set_window(11'd0, 11'd318, 11'd1, 11'd1024);
    repeat (3) send_pixel(16'($urandom));
    drain();
  endtask

  task automatic test_empty_window;
    set_window(11'd5, 11'd5, 11'd0, 11'd4);
    repeat (2) send_pixel(16'($urandom));
    drain();
    set_window(11'd5, 11'd5, 11'd4, 11'd0);
    send_pixel(16'($urandom));
    drain();
    // upper bit of the position registers is dropped, so this is column 1023
    set_window(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
    send_pixel(16'($urandom));
    drain();
  endtask

  task automatic test_backpressure;
    gap_pct = 0;
    stall_pct = 0;
    set_window(11'd100, 11'd200, 11'd7, 11'd3);
    @(posedge clk);
    hold_cycles = 60;
    repeat (30) send_pixel(16'($urandom));
    drain();
  endtask

  task automatic test_random_windows(input int sender_idle, input int receiver_stall,
                                     input int item_target);
    int done, burst, w, h;
    gap_pct = sender_idle;
    stall_pct = receiver_stall;
    done = 0;
    while (done < item_target) begin
      drain();
      case ($urandom_range(9))
        0: set_window(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
        1: write_reg(CFG_IDX_W'($urandom_range(3)), 11'($urandom));
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 6);
          set_window(11'($urandom_range(DISPLAY_WIDTH - 1)),
                     11'($urandom_range(DISPLAY_HEIGHT - 1)), 11'(w), 11'(h));
        end
      endcase
      burst = $urandom_range(1, 40);
      repeat (burst) send_pixel(16'($urandom));
      done += burst;
    end
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW_LEFT;
    cfg_wdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    pixels_sent = 0;
    pixels_written = 0;
    pixels_dropped = 0;
    reg_writes = 0;
    win_left = '0;
    win_top = '0;
    win_width = 11'd1;
    win_height = 11'd1;
    cur_col = '0;
    cur_row = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_window();
    test_color_channels();
    test_display_corner();
    test_window_past_edge();
    test_empty_window();
    test_backpressure();
    test_random_windows(0, 0, 410);
    test_random_windows(81, 0, 410);
    test_random_windows(0, 81, 410);
    test_random_windows(33, 33, 410);

    drain();
    repeat (5) @(posedge clk);
    $display("Run covered %0d pixels (%0d written, %0d dropped) and %0d register writes,",
             pixels_sent, pixels_written, pixels_dropped, reg_writes);
    $display("with corner, clipped and empty windows, a long output stall and four idle mixes.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", pending_writes.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- lcd_window_pixel_writer.f -----
src/lwpw_pkg.sv
src/lwpw_cursor.sv
src/lwpw_out_buf.sv
src/lcd_window_pixel_writer.sv
dv/tb_lcd_window_pixel_writer.sv
